// ----- design/ssch_pkg.sv -----
// Shared types, constants and helpers for the stride scheduler.
// No dependencies; every other design file uses this package.
`timescale 1ns / 1ps

package ssch_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int ID_W      = 4;
	localparam int PRIO_W    = 16;
	localparam int SLICE_W   = 8;
	localparam int STRIDE_W  = 32;
	localparam int QCNT_W    = 5;
	localparam int DIV_STEPS = STRIDE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [STRIDE_W-1:0] FULL_STRIDE = 32'h7FFF_FFFF;
	localparam logic [SLICE_W-1:0]  SLICE_RST   = 8'd5;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_PICK = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	// Broadcast of a single-cycle command to the row of cells
	typedef struct packed {
		logic               en;
		cmd_t               cmd;
		logic [SLOT_W-1:0]  id;
		logic [PRIO_W-1:0]  prio;
		logic               fresh;
		logic [SLICE_W-1:0] max_slice;
	} op_t;

	// Stride advance of the pick winner
	typedef struct packed {
		logic                add_en;
		logic [SLOT_W-1:0]   id;
		logic [STRIDE_W-1:0] step;
	} upd_t;

	// Running minimum handed from cell to cell during a pick scan
	typedef struct packed {
		logic                tok;
		logic                have;
		logic [SLOT_W-1:0]   id;
		logic [STRIDE_W-1:0] stride;
		logic [PRIO_W-1:0]   prio;
	} cand_t;

	typedef struct packed {
		logic queued;
		logic slice_le1;
	} stat_t;

	typedef struct packed {
		logic [ID_W-1:0]   picked_id;
		logic              found;
		logic              resched;
		logic [QCNT_W-1:0] qcount;
	} res_t;

	// a is ahead of b under wrapping signed comparison
	function automatic logic stride_after(logic [STRIDE_W-1:0] a, logic [STRIDE_W-1:0] b);
		logic [STRIDE_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[STRIDE_W-1];
	endfunction

endpackage

// ----- design/ssch_cmd_if.sv -----
// Command channel of the stride scheduler: valid/ready plus one command item.
// Uses widths from ssch_pkg.
`timescale 1ns / 1ps

interface ssch_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   cmd;
	logic [ssch_pkg::ID_W-1:0]    proc_id;
	logic [ssch_pkg::PRIO_W-1:0]  priority_req;
	logic                         fresh;

	modport source(output valid, output cmd, output proc_id, output priority_req,
		output fresh, input ready);
	modport sink(input valid, input cmd, input proc_id, input priority_req,
		input fresh, output ready);
endinterface

// ----- design/ssch_res_if.sv -----
// Result channel of the stride scheduler: valid/ready plus one result item.
// Uses widths from ssch_pkg.
`timescale 1ns / 1ps

interface ssch_res_if;
	logic                         valid;
	logic                         ready;
	logic [ssch_pkg::ID_W-1:0]    picked_id;
	logic                         picked_found;
	logic                         slice_expired;
	logic [ssch_pkg::QCNT_W-1:0]  queued_count;

	modport source(output valid, output picked_id, output picked_found,
		output slice_expired, output queued_count, input ready);
	modport sink(input valid, input picked_id, input picked_found,
		input slice_expired, input queued_count, output ready);
endinterface

// ----- design/ssch_cell.sv -----
// One process slot: stride, priority, slice and queued flag, plus one stage of
// the pick scan chain. Depends on ssch_pkg.
`timescale 1ns / 1ps

module ssch_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ssch_pkg::SLOT_W-1:0] idx,
	input  ssch_pkg::op_t              op,
	input  ssch_pkg::upd_t             upd,
	input  ssch_pkg::cand_t            cand_in,
	output ssch_pkg::cand_t            cand_out,
	output ssch_pkg::stat_t            stat
);
	import ssch_pkg::*;

	logic [STRIDE_W-1:0] stride_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [SLICE_W-1:0]  slice_q;
	logic                queued_q;
	logic                cand_tok_q;
	cand_t               cand_q;
	logic                hit;
	logic                take;

	assign hit  = op.en && (op.id == idx);
	// ties keep the earlier (lower) slot
	assign take = queued_q && (!cand_in.have || stride_after(cand_in.stride, stride_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= '0;
			prio_q   <= '0;
			slice_q  <= '0;
			queued_q <= 1'b0;
		end else begin
			if (hit) begin
				unique case (op.cmd)
					CMD_ENQ: begin
						prio_q   <= op.prio;
						queued_q <= 1'b1;
						if (op.fresh)
							stride_q <= '0;
						if (slice_q == '0 || slice_q > op.max_slice)
							slice_q <= op.max_slice;
					end
					CMD_DEQ: queued_q <= 1'b0;
					CMD_TICK: begin
						if (slice_q != '0)
							slice_q <= slice_q - 1'b1;
					end
					default: ;
				endcase
			end
			if (upd.add_en && upd.id == idx)
				stride_q <= stride_q + upd.step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cand_tok_q <= 1'b0;
		else
			cand_tok_q <= cand_in.tok;
	end

	// advance the running minimum one cell per cycle
	always_ff @(posedge clk) begin
		if (cand_in.tok) begin
			if (take) begin
				cand_q.have   <= 1'b1;
				cand_q.id     <= idx;
				cand_q.stride <= stride_q;
				cand_q.prio   <= prio_q;
			end else begin
				cand_q.have   <= cand_in.have;
				cand_q.id     <= cand_in.id;
				cand_q.stride <= cand_in.stride;
				cand_q.prio   <= cand_in.prio;
			end
		end
	end

	always_comb begin
		cand_out.tok    = cand_tok_q;
		cand_out.have   = cand_q.have;
		cand_out.id     = cand_q.id;
		cand_out.stride = cand_q.stride;
		cand_out.prio   = cand_q.prio;
	end

	assign stat.queued    = queued_q;
	assign stat.slice_le1 = (slice_q <= SLICE_W'(1));

endmodule

// ----- design/ssch_div.sv -----
// Bit-serial restoring divider: FULL_STRIDE / divisor, one quotient bit a cycle.
// A zero divisor yields FULL_STRIDE. Depends on ssch_pkg.
`timescale 1ns / 1ps

module ssch_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ssch_pkg::PRIO_W-1:0]  divisor,
	output logic                         done,
	output logic [ssch_pkg::STRIDE_W-1:0] quot
);
	import ssch_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PRIO_W-1:0]    divisor_q;
	logic [PRIO_W-1:0]    rem_q;
	logic [STRIDE_W-1:0]  dq_q;
	logic [PRIO_W:0]      rem_sh;
	logic                 ge;
	logic [PRIO_W-1:0]    rem_nx;
	logic                 last;

	assign rem_sh = {rem_q, dq_q[STRIDE_W-1]};
	assign ge     = rem_sh >= {1'b0, divisor_q};
	assign rem_nx = ge ? PRIO_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[PRIO_W-1:0];
	assign last   = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= (start && divisor == '0) || (busy_q && last);
			if (start) begin
				busy_q <= (divisor != '0);
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last)
					busy_q <= 1'b0;
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			dq_q      <= FULL_STRIDE;
			rem_q     <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[STRIDE_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule

// ----- design/stride_scheduler_core.sv -----
// Stride scheduler top level: row of slot cells, serial divider, control.
// Depends on ssch_pkg, ssch_cmd_if, ssch_res_if, ssch_cell, ssch_div.
//
// Usage:
//  cmd_ch carries one command item (enqueue, dequeue, pick next, tick) under
//  valid/ready; res_ch returns exactly one result item per command, in order.
//  cfg_we/cfg_wdata write the slice limit, taken at any clock edge with cfg_we.
// Operation:
//  Enqueue, dequeue and tick finish in the accept cycle; the result goes to
//  the output register (the skid entry while it is held); the next item can
//  be taken in the following cycle unless the skid is full. Pick sweeps a
//  token down the row of NUM_SLOTS cells, one cell a cycle, then runs the
//  32-step serial divider for the stride step (skipped for priority zero);
//  an empty queue answers as the token leaves. One item is in work at a time.
// Reset:
//  arst_n clears every slot, the queued count and sets the slice limit to 5.
// Stall:
//  An output register plus a one-entry skid stage hold results; a new item is
//  taken while a result waits, and cmd_ch.ready drops once the skid is full.
`timescale 1ns / 1ps

module stride_scheduler_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ssch_pkg::SLICE_W-1:0] cfg_wdata,
	ssch_cmd_if.sink                     cmd_ch,
	ssch_res_if.source                   res_ch
);
	import ssch_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DIV  = 3'b100
	} state_t;

	state_t              st_q, st_d;
	logic [SLICE_W-1:0]  max_slice_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [SLOT_W-1:0]   win_id_q;
	logic                out_valid_q, skid_valid_q;
	res_t                out_q, skid_q;

	cmd_t                cmd;
	logic                in_acc;
	logic                id_ok;
	logic [SLOT_W-1:0]   id_sel;
	op_t                 op;
	upd_t                upd;
	cand_t               cand [NUM_SLOTS+1];
	stat_t               stat [NUM_SLOTS];
	stat_t               tgt;
	logic [NUM_SLOTS-1:0] queued_vec;
	logic                scan_start, div_start, div_done, add_en;
	logic [STRIDE_W-1:0] div_quot;
	logic                res_new, out_free;
	res_t                res_d;

	assign cmd     = cmd_t'(cmd_ch.cmd);
	assign in_acc  = cmd_ch.valid && cmd_ch.ready;
	assign id_ok   = 32'(cmd_ch.proc_id) < 32'(NUM_SLOTS);
	assign id_sel  = SLOT_W'(cmd_ch.proc_id);
	assign tgt     = stat[id_sel];
	assign cmd_ch.ready = (st_q == S_IDLE) && !skid_valid_q;

	assign op.en        = in_acc && id_ok && (cmd != CMD_PICK);
	assign op.cmd       = cmd;
	assign op.id        = id_sel;
	assign op.prio      = cmd_ch.priority_req;
	assign op.fresh     = cmd_ch.fresh;
	assign op.max_slice = max_slice_q;

	assign upd.add_en = add_en;
	assign upd.id     = win_id_q;
	assign upd.step   = div_quot;

	always_comb begin
		cand[0]        = '0;
		cand[0].tok    = scan_start;
	end

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		ssch_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (SLOT_W'(i)),
			.op       (op),
			.upd      (upd),
			.cand_in  (cand[i]),
			.cand_out (cand[i+1]),
			.stat     (stat[i])
		);
		assign queued_vec[i] = stat[i].queued;
	end

	ssch_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (cand[NUM_SLOTS].prio),
		.done    (div_done),
		.quot    (div_quot)
	);

	always_comb begin
		st_d       = st_q;
		count_d    = count_q;
		scan_start = 1'b0;
		div_start  = 1'b0;
		add_en     = 1'b0;
		res_new    = 1'b0;
		res_d      = '0;
		res_d.qcount = QCNT_W'(count_q);
		unique case (st_q)
			S_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_PICK) begin
						scan_start = 1'b1;
						st_d       = S_SCAN;
					end else begin
						res_new = 1'b1;
						unique case (cmd)
							CMD_ENQ: begin
								if (id_ok && !tgt.queued)
									count_d = count_q + 1'b1;
							end
							CMD_DEQ: begin
								if (id_ok && tgt.queued)
									count_d = count_q - 1'b1;
							end
							CMD_TICK: res_d.resched = id_ok && tgt.slice_le1;
							default: ;
						endcase
						res_d.qcount = QCNT_W'(count_d);
					end
				end
			end
			S_SCAN: begin
				if (cand[NUM_SLOTS].tok) begin
					if (cand[NUM_SLOTS].have) begin
						div_start = 1'b1;
						st_d      = S_DIV;
					end else begin
						res_new = 1'b1;
						st_d    = S_IDLE;
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					add_en          = 1'b1;
					res_new         = 1'b1;
					res_d.picked_id = ID_W'(win_id_q);
					res_d.found     = 1'b1;
					st_d            = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= '0;
			max_slice_q <= SLICE_RST;
		end else begin
			st_q    <= st_d;
			count_q <= count_d;
			if (cfg_we)
				max_slice_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start)
			win_id_q <= cand[NUM_SLOTS].id;
	end

	// output register with one skid entry behind it
	assign out_free = !out_valid_q || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_new;
			skid_valid_q <= skid_valid_q && res_new;
		end else if (res_new) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (res_new)
					skid_q <= res_d;
			end else if (res_new) begin
				out_q <= res_d;
			end
		end else if (res_new) begin
			skid_q <= res_d;
		end
	end

	assign res_ch.valid         = out_valid_q;
	assign res_ch.picked_id     = out_q.picked_id;
	assign res_ch.picked_found  = out_q.found;
	assign res_ch.slice_expired = out_q.resched;
	assign res_ch.queued_count  = out_q.qcount;

	a_skid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_new |-> (!skid_valid_q || out_free))
		else $error("result produced with skid and output both full");

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(queued_vec)))
		else $error("queued count disagrees with cell flags");

	a_scan_exit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cand[NUM_SLOTS].tok |-> (st_q == S_SCAN))
		else $error("scan token left the row outside a scan");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == S_DIV))
		else $error("divider finished outside the divide phase");

	a_pick_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_start |=> (st_q == S_SCAN) && cand[1].tok)
		else $error("pick did not launch the scan token");

endmodule
